>>> src/dcp_pkg.sv
// Shared types and constants for the decimal confidence parser.
package dcp_pkg;

  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int STATUS_W    = 2;
  localparam int CONF_W      = 14;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_DIGIT = 2'd0,
    KIND_DOT   = 2'd1,
    KIND_OTHER = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic {
    PH_INTEGER  = 1'b0,
    PH_FRACTION = 1'b1
  } phase_e;

  typedef struct packed {
    kind_e               kind;
    logic [DIGIT_W-1:0]  digit;
  } item_t;

  function automatic int pow10(int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

endpackage

>>> src/dcp_front.sv
// Front end: accept characters and classify them into queue items.
module dcp_front (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dcp_pkg::CHAR_W-1:0]  character_i,
  input  logic                        end_of_text_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output dcp_pkg::item_t              push_item_o
);

  logic [dcp_pkg::CHAR_W-1:0] offset;

  assign offset       = character_i - dcp_pkg::CHAR_ZERO;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_item_o.digit = offset[dcp_pkg::DIGIT_W-1:0];
    if (end_of_text_i) begin
      push_item_o.kind = dcp_pkg::KIND_END;
    end else if (character_i inside {[dcp_pkg::CHAR_ZERO:dcp_pkg::CHAR_NINE]}) begin
      push_item_o.kind = dcp_pkg::KIND_DIGIT;
    end else if (character_i == dcp_pkg::CHAR_DOT) begin
      push_item_o.kind = dcp_pkg::KIND_DOT;
    end else begin
      push_item_o.kind = dcp_pkg::KIND_OTHER;
    end
  end

endmodule

>>> src/dcp_queue.sv
// Short queue of classified items between the front and back ends.
module dcp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  dcp_pkg::item_t  push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output dcp_pkg::item_t  pop_item_o
);

  localparam int PtrW = $clog2(dcp_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(dcp_pkg::QUEUE_DEPTH + 1);

  dcp_pkg::item_t  mem_q [dcp_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(dcp_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_ready_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(dcp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(dcp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> src/dcp_back.sv
// Back end: parse state, fraction accumulation and the result register.
module dcp_back #(
  parameter int FracDigits = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  dcp_pkg::item_t                 pop_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dcp_pkg::STATUS_W-1:0]   status_o,
  output logic [dcp_pkg::CONF_W-1:0]     confidence_o
);

  localparam int Scale = dcp_pkg::pow10(FracDigits);
  localparam int FracW = $clog2(Scale);
  localparam int TotW  = FracW + 1;
  localparam int CntW  = $clog2(FracDigits + 1);
  localparam int MulW  = FracW + dcp_pkg::DIGIT_W;

  function automatic logic [FracW-1:0] weight(logic [CntW-1:0] n);
    logic [FracW-1:0] w;
    w = '0;
    for (int i = 0; i < FracDigits; i++) begin
      if (n == CntW'(i)) begin
        w = FracW'(dcp_pkg::pow10(FracDigits - 1 - i));
      end
    end
    return w;
  endfunction

  dcp_pkg::phase_e    phase_q, phase_d;
  dcp_pkg::status_e   err_q, err_d;
  logic               whole_q, whole_d;
  logic               saw_q, saw_d;
  logic [FracW-1:0]   frac_q, frac_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [dcp_pkg::STATUS_W-1:0] status_q, status_d;
  logic [dcp_pkg::CONF_W-1:0]   conf_q, conf_d;

  logic               is_end;
  logic               pop;
  logic [MulW-1:0]    frac_sum;
  logic [TotW-1:0]    total;
  dcp_pkg::status_e   final_status;

  assign is_end = (pop_item_i.kind == dcp_pkg::KIND_END);
  assign pop    = pop_valid_i & pop_ready_o;

  assign frac_sum = MulW'(frac_q)
                  + MulW'(pop_item_i.digit) * MulW'(weight(cnt_q));
  assign total    = (whole_q ? TotW'(Scale) : '0) + TotW'(frac_q);

  always_comb begin
    pop_ready_o = !is_end || !out_valid_q || out_ready_i;
  end

  always_comb begin
    final_status = err_q;
    if (err_q == dcp_pkg::ST_OK && !saw_q) begin
      final_status = dcp_pkg::ST_MALFORMED;
    end else if (err_q == dcp_pkg::ST_OK && total > TotW'(Scale)) begin
      final_status = dcp_pkg::ST_RANGE;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    err_d       = err_q;
    whole_d     = whole_q;
    saw_d       = saw_q;
    frac_d      = frac_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    conf_d      = conf_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (pop) begin
      if (is_end) begin
        out_valid_d = 1'b1;
        status_d    = final_status;
        conf_d      = (final_status == dcp_pkg::ST_OK) ? dcp_pkg::CONF_W'(total) : '0;
        phase_d     = dcp_pkg::PH_INTEGER;
        err_d       = dcp_pkg::ST_OK;
        whole_d     = 1'b0;
        saw_d       = 1'b0;
        frac_d      = '0;
        cnt_d       = '0;
      end else if (err_q == dcp_pkg::ST_OK) begin
        case (phase_q)
          dcp_pkg::PH_INTEGER: begin
            if (pop_item_i.kind == dcp_pkg::KIND_DIGIT) begin
              if (whole_q || pop_item_i.digit > dcp_pkg::DIGIT_W'(1)) begin
                err_d = dcp_pkg::ST_RANGE;
              end else begin
                whole_d = pop_item_i.digit[0];
                saw_d   = 1'b1;
              end
            end else if (saw_q && pop_item_i.kind == dcp_pkg::KIND_DOT) begin
              phase_d = dcp_pkg::PH_FRACTION;
            end else begin
              err_d = dcp_pkg::ST_MALFORMED;
            end
          end
          dcp_pkg::PH_FRACTION: begin
            if (pop_item_i.kind != dcp_pkg::KIND_DIGIT) begin
              err_d = dcp_pkg::ST_MALFORMED;
            end else if (cnt_q >= CntW'(FracDigits)) begin
              if (pop_item_i.digit != '0) begin
                err_d = dcp_pkg::ST_MALFORMED;
              end
            end else begin
              frac_d = frac_sum[FracW-1:0];
              cnt_d  = cnt_q + 1'b1;
            end
          end
          default: begin
            err_d = dcp_pkg::ST_MALFORMED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dcp_pkg::PH_INTEGER;
      err_q       <= dcp_pkg::ST_OK;
      whole_q     <= 1'b0;
      saw_q       <= 1'b0;
      frac_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      err_q       <= err_d;
      whole_q     <= whole_d;
      saw_q       <= saw_d;
      frac_q      <= frac_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    conf_q   <= conf_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign confidence_o = conf_q;

endmodule

>>> src/decimal_confidence_parser.sv
// Top level of the decimal confidence parser.
// Input channel: one transaction per text byte on character_i, or an end
// transaction with end_of_text_i high that closes the text.
// Output channel: one transaction per end transaction, carrying status_o
// (0 ok, 1 malformed, 2 out of range) and confidence_o in units of
// 10^-FracDigits (zero unless status is ok).
// Throughput: one input transaction per cycle, sustained while no end transaction is stalled.
// Result path: an accepted end transaction is written into the two-entry
// item queue and, once popped from its head, is loaded into the back-end
// result register that drives out_valid_o.
// Character transactions keep flowing while a result waits to be taken; an
// end transaction stalls at the head of the queue only while the result
// register is still full, and the queue then fills and drops in_ready_o.
// Reset empties the queue, clears the parse state and drops out_valid_o.
// After each end transaction the parse state returns to its reset value.
module decimal_confidence_parser #(
  parameter int FracDigits = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dcp_pkg::CHAR_W-1:0]    character_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dcp_pkg::STATUS_W-1:0]  status_o,
  output logic [dcp_pkg::CONF_W-1:0]    confidence_o
);

  logic           push_valid, push_ready;
  dcp_pkg::item_t push_item;
  logic           pop_valid, pop_ready;
  dcp_pkg::item_t pop_item;

  dcp_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .character_i   (character_i),
    .end_of_text_i (end_of_text_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  dcp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  dcp_back #(
    .FracDigits (FracDigits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .confidence_o (confidence_o)
  );

endmodule

>>> test/tb.sv
// Self-checking testbench for the decimal confidence parser: directed table, held output side, then random texts.
`timescale 1ns / 100ps

module tb;

  localparam int FRAC_DIGITS    = 4;
  localparam int UNIT_SCALE     = 10000;
  localparam int TOTAL_ITEMS    = 1950;
  localparam int DRAIN_EVERY    = 400;
  localparam int HOLD_CYCLES    = 80;
  localparam int HOLD_TEXTS     = 30;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    dcp_pkg::status_e            st;
    logic [dcp_pkg::CONF_W-1:0]  conf;
  } result_t;

  typedef struct {
    logic [dcp_pkg::CHAR_W-1:0]  ch;
    logic                        eot;
    logic                        fixed;
    dcp_pkg::status_e            st;
    logic [dcp_pkg::CONF_W-1:0]  conf;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [dcp_pkg::CHAR_W-1:0]    character_i;
  logic                          end_of_text_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [dcp_pkg::STATUS_W-1:0]  status_o;
  logic [dcp_pkg::CONF_W-1:0]    confidence_o;

  dcp_pkg::phase_e               text_phase;
  logic                          int_value;
  logic                          int_seen;
  logic [dcp_pkg::CONF_W-1:0]    frac_acc;
  int                            frac_digits;
  dcp_pkg::status_e              first_err;

  result_t                       expected_results[$];
  logic [dcp_pkg::CHAR_W-1:0]    text_buf[$];
  int                            items_sent;
  int                            texts_sent;
  int                            mismatches;
  int                            got_ok;
  int                            got_malformed;
  int                            got_range;
  int                            quiet_cycles;
  logic                          hold_off_req;

  dir_row_t dir_rows [0:22] = '{
    '{8'hFF, 1'b1, 1'b1, dcp_pkg::ST_MALFORMED, 14'd0},
    '{"1",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{8'h00, 1'b1, 1'b1, dcp_pkg::ST_OK,        14'd10000},
    '{"1",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{"0",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{8'h00, 1'b1, 1'b1, dcp_pkg::ST_RANGE,     14'd0},
    '{".",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{"5",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{8'h00, 1'b1, 1'b1, dcp_pkg::ST_MALFORMED, 14'd0},
    '{"1",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{".",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{8'h00, 1'b1, 1'b1, dcp_pkg::ST_OK,        14'd10000},
    '{"0",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{8'h00, 1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{8'h00, 1'b1, 1'b1, dcp_pkg::ST_MALFORMED, 14'd0},
    '{"0",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{".",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{".",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{8'h00, 1'b1, 1'b1, dcp_pkg::ST_MALFORMED, 14'd0},
    '{"1",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{".",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{"1",   1'b0, 1'b0, dcp_pkg::ST_OK,        14'd0},
    '{8'h00, 1'b1, 1'b1, dcp_pkg::ST_RANGE,     14'd0}
  };

  decimal_confidence_parser #(
    .FracDigits(FRAC_DIGITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .character_i  (character_i),
    .end_of_text_i(end_of_text_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .confidence_o (confidence_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic clear_parse();
    text_phase  = dcp_pkg::PH_INTEGER;
    int_value   = 1'b0;
    int_seen    = 1'b0;
    frac_acc    = '0;
    frac_digits = 0;
    first_err   = dcp_pkg::ST_OK;
  endtask

  task automatic parse_char(input logic [dcp_pkg::CHAR_W-1:0] ch);
    logic                        is_digit;
    logic [dcp_pkg::DIGIT_W-1:0] d;
    is_digit = (ch >= dcp_pkg::CHAR_ZERO) && (ch <= dcp_pkg::CHAR_NINE);
    d = is_digit ? dcp_pkg::DIGIT_W'(ch - dcp_pkg::CHAR_ZERO) : '0;
    if (first_err == dcp_pkg::ST_OK) begin
      if (text_phase == dcp_pkg::PH_INTEGER) begin
        if (is_digit) begin
          if (int_value != 1'b0 || d > 1) begin
            first_err = dcp_pkg::ST_RANGE;
          end else begin
            int_value = d[0];
            int_seen  = 1'b1;
          end
        end else if (!int_seen) begin
          first_err = dcp_pkg::ST_MALFORMED;
        end else if (ch == dcp_pkg::CHAR_DOT) begin
          text_phase = dcp_pkg::PH_FRACTION;
        end else begin
          first_err = dcp_pkg::ST_MALFORMED;
        end
      end else if (!is_digit) begin
        first_err = dcp_pkg::ST_MALFORMED;
      end else if (frac_digits >= FRAC_DIGITS) begin
        if (d != 0) first_err = dcp_pkg::ST_MALFORMED;
      end else begin
        frac_acc = dcp_pkg::CONF_W'(frac_acc * 10 + d);
        frac_digits++;
      end
    end
  endtask

  function automatic result_t close_text();
    result_t r;
    int      frac;
    int      total;
    r.st   = first_err;
    r.conf = '0;
    if (r.st == dcp_pkg::ST_OK && !int_seen) r.st = dcp_pkg::ST_MALFORMED;
    if (r.st == dcp_pkg::ST_OK) begin
      frac = int'(frac_acc);
      for (int n = frac_digits; n < FRAC_DIGITS; n++) frac = frac * 10;
      total = int'(int_value) * UNIT_SCALE + frac;
      if (total > UNIT_SCALE) r.st = dcp_pkg::ST_RANGE;
      else r.conf = total[dcp_pkg::CONF_W-1:0];
    end
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(input logic [dcp_pkg::CHAR_W-1:0] ch, input logic eot,
                      input logic fixed, input result_t fixed_r);
    logic    took;
    result_t exp_r;
    in_valid_i    <= 1'b1;
    character_i   <= ch;
    end_of_text_i <= eot;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (took !== 1'b1);
    items_sent++;
    if (eot) begin
      if (fixed) exp_r = fixed_r;
      else exp_r = close_text();
      expected_results.insert(expected_results.size(), exp_r);
      texts_sent++;
      clear_parse();
    end else begin
      parse_char(ch);
    end
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid_i    <= 1'b0;
      character_i   <= dcp_pkg::CHAR_W'($urandom_range(0, 255));
      end_of_text_i <= 1'($urandom_range(0, 1));
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i);
    while (expected_results.size() != 0);
  endtask

  task automatic build_text();
    int                         n_int;
    int                         n_frac;
    int                         r;
    int                         pos;
    logic [dcp_pkg::CHAR_W-1:0] c;
    text_buf.delete();
    if ($urandom_range(0, 99) < 8) begin
      n_int = $urandom_range(0, 5);
      repeat (n_int) begin
        text_buf.insert(text_buf.size(), dcp_pkg::CHAR_W'($urandom_range(0, 255)));
      end
    end else begin
      n_int = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      for (int i = 0; i < n_int; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) c = dcp_pkg::CHAR_ZERO;
        else if (r < 85) c = dcp_pkg::CHAR_ZERO + 8'd1;
        else c = dcp_pkg::CHAR_ZERO + dcp_pkg::CHAR_W'($urandom_range(0, 9));
        text_buf.insert(text_buf.size(), c);
      end
      if ($urandom_range(0, 3) != 0) begin
        text_buf.insert(text_buf.size(), dcp_pkg::CHAR_DOT);
        n_frac = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        for (int i = 0; i < n_frac; i++) begin
          if (i >= FRAC_DIGITS) begin
            c = ($urandom_range(0, 99) < 85) ? dcp_pkg::CHAR_ZERO
              : dcp_pkg::CHAR_ZERO + dcp_pkg::CHAR_W'($urandom_range(1, 9));
          end else if ($urandom_range(0, 2) == 0) begin
            c = dcp_pkg::CHAR_ZERO;
          end else begin
            c = dcp_pkg::CHAR_ZERO + dcp_pkg::CHAR_W'($urandom_range(0, 9));
          end
          text_buf.insert(text_buf.size(), c);
        end
      end
      if ($urandom_range(0, 99) < 15) begin
        pos = $urandom_range(0, text_buf.size());
        c = ($urandom_range(0, 1) == 0) ? dcp_pkg::CHAR_DOT
          : dcp_pkg::CHAR_W'($urandom_range(0, 255));
        text_buf.insert(pos, c);
      end
    end
  endtask

  task automatic note_mismatch(input string what, input result_t exp_r);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s: expected status %0d confidence %0d, got status %0d confidence %0d",
               $realtime, what, exp_r.st, exp_r.conf, status_o, confidence_o);
    end
  endtask

  always @(negedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (status_o == dcp_pkg::ST_OK) got_ok++;
      else if (status_o == dcp_pkg::ST_MALFORMED) got_malformed++;
      else got_range++;
      if (expected_results.size() == 0) begin
        exp_r.st   = dcp_pkg::ST_OK;
        exp_r.conf = '0;
        note_mismatch("result with none pending", exp_r);
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.st || confidence_o !== exp_r.conf) begin
          note_mismatch("result mismatch", exp_r);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int   stall_left;
    logic calm;
    out_ready_i = 1'b0;
    stall_left  = 0;
    calm        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ready_i <= 1'b0;
      end else if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        if ($urandom_range(0, 199) == 0) calm = !calm;
        if (stall_left > 0) begin
          out_ready_i <= 1'b0;
          stall_left--;
        end else begin
          out_ready_i <= 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
        end
      end
    end
  end

  initial begin
    result_t no_fix;
    result_t row_r;
    logic    burst;
    int      next_drain;
    in_valid_i    = 1'b0;
    character_i   = '0;
    end_of_text_i = 1'b0;
    rst_ni        = 1'b0;
    hold_off_req  = 1'b0;
    items_sent    = 0;
    texts_sent    = 0;
    mismatches    = 0;
    got_ok        = 0;
    got_malformed = 0;
    got_range     = 0;
    quiet_cycles  = 0;
    no_fix.st     = dcp_pkg::ST_OK;
    no_fix.conf   = '0;
    clear_parse();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row_r.st   = dir_rows[i].st;
      row_r.conf = dir_rows[i].conf;
      send(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].fixed, row_r);
      idle_gap(idle_len());
    end
    drain();

    // hold the result side while short texts pile up behind it
    hold_off_req = 1'b1;
    repeat (HOLD_TEXTS) begin
      send("1", 1'b0, 1'b0, no_fix);
      send(dcp_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b0, no_fix);
    end
    drain();

    next_drain = items_sent + DRAIN_EVERY;
    while (items_sent < TOTAL_ITEMS) begin
      build_text();
      burst = ($urandom_range(0, 5) == 0);
      foreach (text_buf[k]) begin
        send(text_buf[k], 1'b0, 1'b0, no_fix);
        idle_gap(burst ? 0 : idle_len());
      end
      send(dcp_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b0, no_fix);
      idle_gap(burst ? 0 : idle_len());
      if (items_sent >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) mismatches++;
    $display("Parsed %0d texts from %0d input transactions:", texts_sent, items_sent);
    $display("%0d ok, %0d malformed, %0d out of range, %0d result mismatches",
             got_ok, got_malformed, got_range, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/dcp_pkg.sv
src/dcp_front.sv
src/dcp_queue.sv
src/dcp_back.sv
src/decimal_confidence_parser.sv
test/tb.sv
